>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// operation codes, error codes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FUNC_W = 3;
    localparam int ERR_W  = 2;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_SIMP = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_OP   = 2'd1,
        ERR_ZERO = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_GCD_START,
        S_GCD_WAIT,
        S_QN_START,
        S_QN_WAIT,
        S_QD_START,
        S_QD_WAIT,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> design/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider: shared restoring divider
// signed truncating quotient and remainder, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module rau_divider
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [DATA_WIDTH-1:0] i_dividend,
    input  wire logic signed [DATA_WIDTH-1:0] i_divisor,
    output logic                              o_done,
    output logic signed [DATA_WIDTH-1:0]      o_quot,
    output logic signed [DATA_WIDTH-1:0]      o_rem
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_q, n_q;
    logic [DATA_WIDTH:0]   r_r, n_r;
    logic [DATA_WIDTH-1:0] r_d;
    logic                  r_qneg, r_rneg, r_busy, n_busy, r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DATA_WIDTH:0]   trial, diff;
    logic [DATA_WIDTH-1:0] a_mag, b_mag;

    // operand magnitudes
    assign a_mag = i_dividend[DATA_WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign b_mag = i_divisor[DATA_WIDTH-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    // one shift and subtract step
    assign trial = {r_r[DATA_WIDTH-1:0], r_q[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, r_d};

    always_comb begin
        n_q    = r_q;
        n_r    = r_r;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = a_mag;
            n_r    = '0;
            n_cnt  = CW'(DATA_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[DATA_WIDTH]) begin
                n_r = diff;
                n_q = {r_q[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_r = trial;
                n_q = {r_q[DATA_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_d    <= b_mag;
            r_qneg <= i_dividend[DATA_WIDTH-1] ^ i_divisor[DATA_WIDTH-1];
            r_rneg <= i_dividend[DATA_WIDTH-1];
        end
    end

    // sign fix; magnitudes wrap as C does for min by minus one
    assign o_done = r_done;
    assign o_quot = r_qneg ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_rneg ? (~r_r[DATA_WIDTH-1:0] + 1'b1) : r_r[DATA_WIDTH-1:0];
endmodule
`default_nettype wire

>>> design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add, subtract, multiply, divide, simplify
// sequenced over one multiplier and one shared bit-serial divider
// ----------------------------------------------------------------------------
// Usage:
//   the slave channel takes one item: two fractions A, B and an operation
//   code. the master channel returns one item per input: result fraction and
//   an error code. s_axis_tready is high only while the block is idle.
//   Arithmetic operations use registered multiplies into r_p0, r_p1 and r_p2
//   (states S_MUL0 to S_MUL3) and a combine step (S_COMB) before the result.
//   Simplify runs a Euclid loop on the shared divider, one remainder step
//   per division, followed by two more divisions for the reduced parts.
//   Unknown operation codes and, for simplify, a zero A denominator pass A
//   through: result valid the cycle after accept.
//   The result sits in an output register until m_axis_tready takes it; a
//   stalled receiver keeps s_axis_tready low until then.
//   Synchronous active-low reset returns to idle with no result pending.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // func, a_num, a_den, b_num, b_den from bit 0 up, zero padded
    input  wire logic [((FUNC_W+4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // res_num, res_den, err_code from bit 0 up, zero padded
    output logic [((ERR_W+2*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);
    localparam int DW  = DATA_WIDTH;
    localparam int OTW = ((ERR_W + 2*DW + 7) / 8) * 8;

    t_state r_state, n_state;
    logic [FUNC_W-1:0]     r_func;
    logic signed [DW-1:0]  r_an, r_ad, r_bn, r_bd;
    logic signed [DW-1:0]  r_p0, r_p1, r_p2;
    logic signed [DW-1:0]  r_ga, r_gb, r_g;
    logic signed [DW-1:0]  r_rn, r_rd;
    logic [ERR_W-1:0]      r_err;
    logic                  r_ovalid;
    logic                  in_acc;
    // multiplier
    logic signed [DW-1:0]  mul_a, mul_b, mul_p;
    // divider
    logic                  div_start, div_done;
    logic signed [DW-1:0]  div_n, div_d, div_q, div_r;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;

    // single multiplier, operands picked by state
    always_comb begin
        unique case (r_state)
            S_MUL0:  begin mul_a = r_an; mul_b = (r_func == OP_MUL) ? r_bn : r_bd; end
            S_MUL1:  begin mul_a = r_ad; mul_b = r_bn; end
            S_MUL2:  begin mul_a = r_ad; mul_b = r_bd; end
            default: begin mul_a = r_ad; mul_b = r_bd; end
        endcase
    end
    assign mul_p = DW'(mul_a * mul_b);

    rau_divider #(.DATA_WIDTH(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // divider launch and operands
    always_comb begin
        div_start = (r_state == S_GCD_START) || (r_state == S_QN_START) ||
                    (r_state == S_QD_START);
        unique case (r_state)
            S_QN_START: begin div_n = r_an; div_d = r_g; end
            S_QD_START: begin div_n = r_ad; div_d = r_g; end
            default:    begin div_n = r_ga; div_d = r_gb; end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) begin
                if (s_axis_tdata[FUNC_W-1:0] == OP_SIMP) begin
                    n_state = (s_axis_tdata[FUNC_W+2*DW-1:FUNC_W+DW] == '0) ?
                              S_OUT : S_GCD_START;
                end else if (s_axis_tdata[FUNC_W-1:0] > OP_SIMP) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0:      n_state = S_MUL1;
            S_MUL1:      n_state = S_MUL2;
            S_MUL2:      n_state = S_MUL3;
            S_MUL3:      n_state = S_COMB;
            S_COMB:      n_state = S_OUT;
            S_GCD_START: n_state = S_GCD_WAIT;
            S_GCD_WAIT: if (div_done) begin
                n_state = (!div_r[DW-1] && div_r != '0) ? S_GCD_START : S_QN_START;
            end
            S_QN_START:  n_state = S_QN_WAIT;
            S_QN_WAIT:   if (div_done) n_state = S_QD_START;
            S_QD_START:  n_state = S_QD_WAIT;
            S_QD_WAIT:   if (div_done) n_state = S_OUT;
            S_OUT:       if (m_axis_tready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (in_acc) begin
                r_func <= s_axis_tdata[FUNC_W-1:0];
                r_an   <= s_axis_tdata[FUNC_W+DW-1:FUNC_W];
                r_ad   <= s_axis_tdata[FUNC_W+2*DW-1:FUNC_W+DW];
                r_bn   <= s_axis_tdata[FUNC_W+3*DW-1:FUNC_W+2*DW];
                r_bd   <= s_axis_tdata[FUNC_W+4*DW-1:FUNC_W+3*DW];
                r_ga   <= s_axis_tdata[FUNC_W+DW-1:FUNC_W];
                r_gb   <= s_axis_tdata[FUNC_W+2*DW-1:FUNC_W+DW];
                r_rn   <= s_axis_tdata[FUNC_W+DW-1:FUNC_W];
                r_rd   <= s_axis_tdata[FUNC_W+2*DW-1:FUNC_W+DW];
                if (s_axis_tdata[FUNC_W-1:0] > OP_SIMP) r_err <= ERR_OP;
                else if (s_axis_tdata[FUNC_W-1:0] == OP_SIMP &&
                         s_axis_tdata[FUNC_W+2*DW-1:FUNC_W+DW] == '0) r_err <= ERR_ZERO;
                else r_err <= ERR_OK;
            end
            S_MUL0: r_p0 <= mul_p;
            S_MUL1: r_p1 <= mul_p;
            S_MUL2: r_p2 <= mul_p;
            S_MUL3: ;
            S_COMB: begin
                unique case (r_func)
                    OP_ADD:  begin r_rn <= r_p0 + r_p1; r_rd <= r_p2; end
                    OP_SUB:  begin r_rn <= r_p0 - r_p1; r_rd <= r_p2; end
                    OP_MUL:  begin r_rn <= r_p0;        r_rd <= r_p2; end
                    default: begin r_rn <= r_p0;        r_rd <= r_p1; end
                endcase
            end
            // euclid: continue while remainder is positive, keep last divisor
            S_GCD_WAIT: if (div_done) begin
                r_ga <= r_gb;
                r_gb <= div_r;
                r_g  <= r_gb;
            end
            S_QN_WAIT: if (div_done) r_rn <= div_q;
            S_QD_WAIT: if (div_done) r_rd <= div_q;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else          r_ovalid <= (n_state == S_OUT);
    end

    assign m_axis_tvalid = r_ovalid && (r_state == S_OUT);
    assign m_axis_tdata  = OTW'({r_err, r_rd, r_rn});
endmodule
`default_nettype wire

>>> design/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: port-level checks for the rational arithmetic unit
// handshake and one-item-in-flight ordering
// ----------------------------------------------------------------------------
`default_nettype none
module rau_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready
);
    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with result pending");

    // accepted item closes input until its result leaves
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    // result delivery returns the block to ready
    a_ready_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
        else $error("not ready after result taken");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
`default_nettype wire
